// ----- rtl/core/ptw_pkg.sv -----
// Package for the four-level page table walker.
// Holds result codes, page size codes and entry bit positions.
// No dependencies.
`default_nettype none

package ptw_pkg;

  localparam int TABLE_ENTRIES = 512;
  localparam int IDX_W         = 9;
  localparam int FRAME_W       = 40;
  localparam int ENTRY_W       = 64;
  localparam int VA_W          = 48;
  localparam int PA_W          = 52;
  localparam int ROOT_W        = 15;

  localparam int PRESENT_POS   = 0;
  localparam int HUGE_POS      = 7;
  localparam int FRAME_LSB     = 12;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_PRESENT = 2'd1,
    ST_OUTSIDE     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SZ_4K = 2'd0,
    SZ_2M = 2'd1,
    SZ_1G = 2'd2
  } size_t_t;

  typedef enum logic {
    KIND_WRITE     = 1'b0,
    KIND_TRANSLATE = 1'b1
  } kind_t;

endpackage

`default_nettype wire

// ----- rtl/core/ptw_store.sv -----
// Table entry store: one write port, one read port with registered data.
// Depends on ptw_pkg for the entry width.
`default_nettype none

module ptw_store #(
  parameter int STORE_WORDS = 4096
) (
  input  wire logic                               clk,
  input  wire logic                               wr_en,
  input  wire logic [$clog2(STORE_WORDS)-1:0]     wr_addr,
  input  wire logic [ptw_pkg::ENTRY_W-1:0]        wr_data,
  input  wire logic [$clog2(STORE_WORDS)-1:0]     rd_addr,
  output logic      [ptw_pkg::ENTRY_W-1:0]        rd_data
);

  logic [ptw_pkg::ENTRY_W-1:0] mem [STORE_WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/four_level_page_table_walker_top.sv -----
// Four-level page table walker, top level: sequencer, config register, result regs.
// Depends on ptw_pkg and ptw_store.
//
// channel   | signals                                          | handshake
// ----------+--------------------------------------------------+--------------------------
// command   | kind, entry_index, entry_value, virt_addr        | start && !busy
// result    | phys_frame, status, page_size                    | done, one cycle, no stall
// config    | cfg_wr_data                                      | cfg_wr_en
//
// A write transaction leaves busy low; its result shows the next cycle.
// A translate transaction holds busy through S_ISSUE and then S_WALK, reading L levels
// (0..4, 0 when the top table lies outside the store), one store read per level through
// the single read port; the result shows the cycle after the last busy state.
// After reset a clearing pass zeroes every store word in turn with busy high.
// The result side cannot stall.
`default_nettype none

module four_level_page_table_walker_top #(
  parameter int STORE_WORDS = 4096
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire logic          kind,
  input  wire logic [11:0]   entry_index,
  input  wire logic [63:0]   entry_value,
  input  wire logic [47:0]   virt_addr,
  input  wire logic          cfg_wr_en,
  input  wire logic [14:0]   cfg_wr_data,
  output logic               done,
  output logic [51:0]        phys_frame,
  output logic [1:0]         status,
  output logic [1:0]         page_size
);

  localparam int AW      = $clog2(STORE_WORDS);
  localparam int NTABLES = STORE_WORDS / ptw_pkg::TABLE_ENTRIES;
  localparam int FW      = ptw_pkg::FRAME_W;
  localparam int IW      = ptw_pkg::IDX_W;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_ISSUE,
    S_WALK
  } state_t;

  state_t                          state;
  logic [AW-1:0]                   clr_addr;
  logic [ptw_pkg::ROOT_W-1:0]      root_base;
  logic [ptw_pkg::VA_W-1:0]        va;
  logic [1:0]                      lvl;
  logic [FW-1:0]                   frame;

  logic                            wr_en;
  logic [AW-1:0]                   wr_addr;
  logic [ptw_pkg::ENTRY_W-1:0]     wr_data;
  logic [AW-1:0]                   rd_addr;
  logic [ptw_pkg::ENTRY_W-1:0]     entry;
  logic [31:0]                     idx32;
  logic                            idx_ok;
  logic                            fits_cur;
  logic                            fits_next;
  logic [FW-1:0]                   next_frame;
  logic                            present;
  logic                            huge;
  logic [FW+IW-1:0]                addr_wide;
  logic [1:0]                      lvl_dn;
  logic                            accept;

  function automatic logic [IW-1:0] idx_sel(input logic [1:0] l,
                                            input logic [ptw_pkg::VA_W-1:0] v);
    logic [IW-1:0] r;
    begin
      case (l)
        2'd3:    r = v[47:39];
        2'd2:    r = v[38:30];
        2'd1:    r = v[29:21];
        default: r = v[20:12];
      endcase
      return r;
    end
  endfunction

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign idx32      = 32'(entry_index);
  assign idx_ok     = idx32 < 32'(STORE_WORDS);
  assign present    = entry[ptw_pkg::PRESENT_POS];
  assign huge       = entry[ptw_pkg::HUGE_POS] && (lvl == 2'd2 || lvl == 2'd1);
  assign next_frame = entry[ptw_pkg::FRAME_LSB +: FW];
  assign fits_cur   = {1'b0, frame} < (FW+1)'(NTABLES);
  assign fits_next  = {1'b0, next_frame} < (FW+1)'(NTABLES);
  assign lvl_dn     = lvl - 2'd1;

  always_comb begin
    if (state == S_WALK) begin
      addr_wide = {next_frame, idx_sel(lvl_dn, va)};
    end else begin
      addr_wide = {frame, idx_sel(lvl, va)};
    end
    rd_addr = addr_wide[AW-1:0];
  end

  always_comb begin
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else begin
      wr_en   = accept && (kind == ptw_pkg::KIND_WRITE) && idx_ok;
      wr_addr = idx32[AW-1:0];
      wr_data = entry_value;
    end
  end

  ptw_store #(
    .STORE_WORDS (STORE_WORDS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      root_base <= '0;
      done      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        root_base <= cfg_wr_data;
      end
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(STORE_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (kind == ptw_pkg::KIND_WRITE) begin
              done       <= 1'b1;
              phys_frame <= '0;
              status     <= ptw_pkg::ST_OK;
              page_size  <= ptw_pkg::SZ_4K;
            end else begin
              va    <= virt_addr;
              lvl   <= 2'd3;
              frame <= FW'(root_base[ptw_pkg::ROOT_W-1:ptw_pkg::FRAME_LSB]);
              state <= S_ISSUE;
            end
          end
        end
        S_ISSUE: begin
          if (!fits_cur) begin
            done       <= 1'b1;
            phys_frame <= '0;
            status     <= ptw_pkg::ST_OUTSIDE;
            page_size  <= ptw_pkg::SZ_4K;
            state      <= S_IDLE;
          end else begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (!present) begin
            done       <= 1'b1;
            phys_frame <= '0;
            status     <= ptw_pkg::ST_NOT_PRESENT;
            page_size  <= ptw_pkg::SZ_4K;
            state      <= S_IDLE;
          end else if (huge || lvl == 2'd0) begin
            done       <= 1'b1;
            phys_frame <= {next_frame, 12'd0};
            status     <= ptw_pkg::ST_OK;
            page_size  <= huge ? lvl : ptw_pkg::SZ_4K;
            state      <= S_IDLE;
          end else if (!fits_next) begin
            done       <= 1'b1;
            phys_frame <= '0;
            status     <= ptw_pkg::ST_OUTSIDE;
            page_size  <= ptw_pkg::SZ_4K;
            state      <= S_IDLE;
          end else begin
            lvl   <= lvl_dn;
            frame <= next_frame;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ptw_checker.sv -----
// Port-level checker for the page table walker, bound to the top level.
// Depends on ptw_pkg for result and command codes.
`default_nettype none

module ptw_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          kind,
  input wire logic          done,
  input wire logic [51:0]   phys_frame,
  input wire logic [1:0]    status,
  input wire logic [1:0]    page_size
);

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != ptw_pkg::ST_OK |-> phys_frame == '0 && page_size == ptw_pkg::SZ_4K)
    else $error("failed transaction carries frame or size");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> status == ptw_pkg::ST_OK || status == ptw_pkg::ST_NOT_PRESENT ||
             status == ptw_pkg::ST_OUTSIDE)
    else $error("undefined status code");

  a_write_done: assert property (@(posedge clk) disable iff (rst)
    start && !busy && kind == ptw_pkg::KIND_WRITE |=>
      done && status == ptw_pkg::ST_OK && phys_frame == '0)
    else $error("write transaction result missing");

  a_walk_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && kind == ptw_pkg::KIND_TRANSLATE |=> busy && !done)
    else $error("translate transaction did not start a walk");

  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> busy && !done)
    else $error("store clearing not running after reset");

endmodule

bind four_level_page_table_walker_top ptw_checker u_ptw_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .kind       (kind),
  .done       (done),
  .phys_frame (phys_frame),
  .status     (status),
  .page_size  (page_size)
);

`default_nettype wire
